>>> sv/msp_pkg.sv
// Shared codes and record types of the message slot pool.
package msp_pkg;

  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_WAIT    = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_RELEASE = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_NO_MATCH = 2'd2;

  localparam logic [4:0] EXPIRED_MAX = 5'd31;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_POSTED  = 2'd1,
    MODE_CLAIMED = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] event_code;
    logic [7:0]  device_id;
    logic [31:0] value;
    logic [15:0] ticks_left;
  } slot_t;

  localparam slot_t IDLE_SLOT = '{
    mode:       MODE_IDLE,
    event_code: 32'd0,
    device_id:  8'd0,
    value:      32'd0,
    ticks_left: 16'd0
  };

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] event_code;
    logic [7:0]  device_id;
    logic [31:0] payload;
    logic [15:0] timeout_ms;
    logic [3:0]  slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic [31:0] value_out;
    logic [4:0]  expired_count;
  } rsp_t;

endpackage

>>> sv/msp_ifs.sv
// Request and result channel interfaces of the message slot pool.
interface msp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] event_code;
  logic [7:0]  device_id;
  logic [31:0] payload;
  logic [15:0] timeout_ms;
  logic [3:0]  slot_index;

  modport source (
    output valid, kind, event_code, device_id, payload, timeout_ms, slot_index,
    input  ready
  );
  modport sink (
    input  valid, kind, event_code, device_id, payload, timeout_ms, slot_index,
    output ready
  );
endinterface

interface msp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic [31:0] value_out;
  logic [4:0]  expired_count;

  modport source (
    output valid, status, slot_out, value_out, expired_count,
    input  ready
  );
  modport sink (
    input  valid, status, slot_out, value_out, expired_count,
    output ready
  );
endinterface

>>> sv/message_slot_pool_with_timeout.sv
// A pool of SLOTS message slots held in a single-port-read store and walked one slot per
// cycle. After reset a clearing pass marks every slot idle; no request is taken until it
// ends. A send or a wait ends the walk at the slot that settles it; a send into a full
// pool, a wait without a match and a tick walk every slot; a release writes its slot
// without a read. The result word sits in an output register, so the next request is
// taken while a result still waits.
module message_slot_pool_with_timeout
  import msp_pkg::*;
#(
  parameter int SLOTS   = 16,
  parameter int TICK_MS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  msp_in_if.sink    in_chan,
  msp_out_if.source out_chan
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  // ceil(2^32 / TICK_MS): exact quotient for any 16-bit timeout
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} state_t;

  state_t             state_r, state_nxt;
  req_t               req_r, req_nxt;
  rsp_t               res_r, res_nxt;
  rsp_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]   ptr_r, ptr_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [4:0]         expired_r, expired_nxt;
  logic [15:0]        tick_q_r;
  logic [48:0]        tick_prod;

  logic               wr_en, rd_en;
  logic [IDX_W-1:0]   wr_addr, rd_addr;
  slot_t              wr_data, rd_data_r;
  logic               in_acc;
  logic               rel_in_range;

  msp_slot_ram #(
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data_r (rd_data_r)
  );

  assign in_acc       = in_chan.valid && in_chan.ready;
  assign rel_in_range = int'(req_r.slot_index) < SLOTS;
  assign tick_prod    = 49'(req_r.timeout_ms) * 49'(RECIP);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    expired_nxt   = expired_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = chk_idx_r;
    wr_data       = rd_data_r;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[IDX_W-1:0];
        wr_data = IDLE_SLOT;
        if (ptr_r == CNT_W'(SLOTS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CNT_W'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          req_nxt.kind       = in_chan.kind;
          req_nxt.event_code = in_chan.event_code;
          req_nxt.device_id  = in_chan.device_id;
          req_nxt.payload    = in_chan.payload;
          req_nxt.timeout_ms = in_chan.timeout_ms;
          req_nxt.slot_index = in_chan.slot_index;
          res_nxt     = '0;
          ptr_nxt     = '0;
          expired_nxt = '0;
          state_nxt   = S_SCAN;
        end
      end

      S_SCAN: begin
        if (req_r.kind == KIND_RELEASE) begin
          // freeing an idle slot changes nothing, so no read is needed
          wr_en     = rel_in_range;
          wr_addr   = IDX_W'(req_r.slot_index);
          wr_data   = IDLE_SLOT;
          res_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          if (ptr_r != CNT_W'(SLOTS)) begin
            rd_en       = 1'b1;
            ptr_nxt     = ptr_r + CNT_W'(1);
            pend_nxt    = 1'b1;
            chk_idx_nxt = ptr_r[IDX_W-1:0];
          end

          if (pend_r) begin
            case (req_r.kind)
              KIND_SEND: begin
                if (rd_data_r.mode == MODE_IDLE) begin
                  wr_en              = 1'b1;
                  wr_data.mode       = MODE_POSTED;
                  wr_data.event_code = req_r.event_code;
                  wr_data.device_id  = req_r.device_id;
                  wr_data.value      = req_r.payload;
                  wr_data.ticks_left = tick_q_r;
                  res_nxt.status     = STATUS_OK;
                  res_nxt.slot_out   = 4'(chk_idx_r);
                  state_nxt          = S_DONE;
                end
              end
              KIND_WAIT: begin
                if (rd_data_r.mode == MODE_POSTED &&
                    rd_data_r.event_code == req_r.event_code &&
                    rd_data_r.device_id == req_r.device_id) begin
                  wr_en             = 1'b1;
                  wr_data.mode      = MODE_CLAIMED;
                  res_nxt.status    = STATUS_OK;
                  res_nxt.slot_out  = 4'(chk_idx_r);
                  res_nxt.value_out = rd_data_r.value;
                  state_nxt         = S_DONE;
                end
              end
              KIND_TICK: begin
                if (rd_data_r.mode == MODE_POSTED && rd_data_r.ticks_left != 16'd0) begin
                  wr_en = 1'b1;
                  if (rd_data_r.ticks_left == 16'd1) begin
                    wr_data = IDLE_SLOT;
                    if (expired_r != EXPIRED_MAX) begin
                      expired_nxt = expired_r + 5'd1;
                    end
                  end else begin
                    wr_data.ticks_left = rd_data_r.ticks_left - 16'd1;
                  end
                end
              end
              default: begin
              end
            endcase
          end else if (ptr_r == CNT_W'(SLOTS)) begin
            // walk finished without a hit
            res_nxt = '0;
            case (req_r.kind)
              KIND_SEND: res_nxt.status = STATUS_FULL;
              KIND_WAIT: res_nxt.status = STATUS_NO_MATCH;
              default:   res_nxt.expired_count = expired_r;
            endcase
            state_nxt = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
      ptr_r       <= '0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ptr_r       <= ptr_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    res_r     <= res_nxt;
    out_r     <= out_nxt;
    chk_idx_r <= chk_idx_nxt;
    expired_r <= expired_nxt;
    tick_q_r  <= tick_prod[47:32];
  end

  assign in_chan.ready          = (state_r == S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_r.status;
  assign out_chan.slot_out      = out_r.slot_out;
  assign out_chan.value_out     = out_r.value_out;
  assign out_chan.expired_count = out_r.expired_count;

  // read and write of one cycle must never meet on the same slot
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("slot store read and write collide");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !wr_en)
    else $error("slot store written outside a request");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.expired_count == 5'd0 || out_chan.status == STATUS_OK))
    else $error("expiry count with failing status");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_CLEAR && state_r == S_CLEAR |-> !out_chan.valid)
    else $error("result word during clearing pass");

endmodule

>>> sv/msp_slot_ram.sv
// Slot store: one write port, one read port with registered read data.
module msp_slot_ram
  import msp_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  slot_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output slot_t         rd_data_r
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

>>> sim/message_slot_pool_with_timeout_test.sv
// Self-checking testbench for the message slot pool with timeout.
`timescale 1ns / 1ps

module message_slot_pool_with_timeout_test;
  import msp_pkg::*;

  localparam int POOL_SLOTS     = 16;
  localparam int TICK_PERIOD_MS = 8;
  localparam int RANDOM_ITEMS   = 1100;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 2 * POOL_SLOTS + 8;
  localparam int STALL_LIMIT    = 2000;

  // Slot pool predictor plus the queue of results still awaited from the block.
  class pool_checker;
    slot_t slots[POOL_SLOTS];
    rsp_t  awaited[$];
    int    mismatches;

    function new();
      foreach (slots[s]) slots[s] = IDLE_SLOT;
      mismatches = 0;
    endfunction

    function rsp_t predict_outcome(req_t r);
      rsp_t o;
      o = '0;
      case (r.kind)
        KIND_SEND: begin
          o.status = STATUS_FULL;
          for (int s = 0; s < POOL_SLOTS; s++) begin
            if (slots[s].mode == MODE_IDLE) begin
              slots[s] = '{mode: MODE_POSTED, event_code: r.event_code,
                           device_id: r.device_id, value: r.payload,
                           ticks_left: 16'(r.timeout_ms / TICK_PERIOD_MS)};
              o.status = STATUS_OK;
              o.slot_out = 4'(s);
              break;
            end
          end
        end
        KIND_WAIT: begin
          o.status = STATUS_NO_MATCH;
          for (int s = 0; s < POOL_SLOTS; s++) begin
            if (slots[s].mode == MODE_POSTED && slots[s].event_code == r.event_code &&
                slots[s].device_id == r.device_id) begin
              slots[s].mode = MODE_CLAIMED;
              o.status = STATUS_OK;
              o.slot_out = 4'(s);
              o.value_out = slots[s].value;
              break;
            end
          end
        end
        KIND_TICK: begin
          // a zero count never runs down, so such a slot stays posted
          foreach (slots[s]) begin
            if (slots[s].mode == MODE_POSTED && slots[s].ticks_left != 16'd0) begin
              slots[s].ticks_left = slots[s].ticks_left - 16'd1;
              if (slots[s].ticks_left == 16'd0) begin
                slots[s] = IDLE_SLOT;
                if (o.expired_count < EXPIRED_MAX) o.expired_count = o.expired_count + 5'd1;
              end
            end
          end
        end
        KIND_RELEASE: begin
          if (int'(r.slot_index) < POOL_SLOTS && slots[r.slot_index].mode != MODE_IDLE)
            slots[r.slot_index] = IDLE_SLOT;
        end
      endcase
      return o;
    endfunction

    function void note_request(req_t r);
      awaited.push_back(predict_outcome(r));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        flag_mismatch("result word with nothing awaited, status", 32'(got.status), 32'd0);
      end else begin
        want = awaited.pop_front();
        if (got.status !== want.status)
          flag_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.slot_out !== want.slot_out)
          flag_mismatch("slot_out", 32'(got.slot_out), 32'(want.slot_out));
        if (got.value_out !== want.value_out)
          flag_mismatch("value_out", got.value_out, want.value_out);
        if (got.expired_count !== want.expired_count)
          flag_mismatch("expired_count", 32'(got.expired_count), 32'(want.expired_count));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  msp_in_if  in_chan();
  msp_out_if out_chan();

  pool_checker pool = new();
  bit          hold_off_due;
  int          quiet_cycles = 0;
  logic [31:0] common_events[4];
  logic [7:0]  common_devices[4];

  message_slot_pool_with_timeout #(
    .SLOTS   (POOL_SLOTS),
    .TICK_MS (TICK_PERIOD_MS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic req_t mk_req(logic [1:0] kind, logic [31:0] evt, logic [7:0] dev,
                                  logic [31:0] pay, logic [15:0] tmo, logic [3:0] idx);
    req_t r;
    r.kind = kind;
    r.event_code = evt;
    r.device_id = dev;
    r.payload = pay;
    r.timeout_ms = tmo;
    r.slot_index = idx;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and bursts with none at all.
  function automatic int pick_gap(int n);
    int pick;
    pick = $urandom_range(0, 99);
    if ((n % 150) < 25 || pick < 45) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Well-formed traffic: events and devices drawn mostly from a small set so waits match.
  function automatic req_t random_request(int phase);
    int pick, send_lim, wait_lim, tick_lim;
    logic [1:0] kind;
    logic [31:0] evt;
    logic [7:0] dev;
    logic [15:0] tmo;
    case (phase)
      0:       begin send_lim = 55; wait_lim = 70; tick_lim = 85; end
      1:       begin send_lim = 30; wait_lim = 70; tick_lim = 85; end
      2:       begin send_lim = 35; wait_lim = 45; tick_lim = 90; end
      default: begin send_lim = 30; wait_lim = 55; tick_lim = 75; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < send_lim) kind = KIND_SEND;
    else if (pick < wait_lim) kind = KIND_WAIT;
    else if (pick < tick_lim) kind = KIND_TICK;
    else kind = KIND_RELEASE;
    evt = ($urandom_range(0, 5) == 0) ? $urandom : common_events[$urandom_range(0, 3)];
    dev = ($urandom_range(0, 5) == 0) ? 8'($urandom) : common_devices[$urandom_range(0, 3)];
    tmo = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 48));
    return mk_req(kind, evt, dev, $urandom, tmo, 4'($urandom_range(0, 15)));
  endfunction

  task automatic offer_request(input req_t r, input int gap);
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.kind       <= r.kind;
    in_chan.event_code <= r.event_code;
    in_chan.device_id  <= r.device_id;
    in_chan.payload    <= r.payload;
    in_chan.timeout_ms <= r.timeout_ms;
    in_chan.slot_index <= r.slot_index;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    pool.note_request(r);
    @(negedge clk);
  endtask

  initial begin : request_source
    req_t directed[$];
    in_chan.valid = 1'b0;
    in_chan.kind = KIND_SEND;
    in_chan.event_code = '0;
    in_chan.device_id = '0;
    in_chan.payload = '0;
    in_chan.timeout_ms = '0;
    in_chan.slot_index = '0;
    rst_n = 1'b0;
    hold_off_due = 1'b0;
    foreach (common_events[k]) common_events[k] = $urandom;
    foreach (common_devices[k]) common_devices[k] = 8'($urandom);

    directed.push_back(mk_req(KIND_WAIT, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_RELEASE, 32'h0, 8'h00, 32'h0, 16'h0, 4'hf));
    directed.push_back(mk_req(KIND_TICK, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_SEND, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 16'hffff, 4'hf));
    directed.push_back(mk_req(KIND_SEND, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_SEND, 32'h1234_5678, 8'h5a, 32'hcafe_f00d, 16'd8, 4'h0));
    directed.push_back(mk_req(KIND_TICK, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_WAIT, 32'hffff_ffff, 8'hff, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_WAIT, 32'hffff_ffff, 8'h00, 32'h0, 16'h0, 4'h0));
    // fill the rest of the pool, one send with a count that rounds down to zero
    for (int k = 0; k < POOL_SLOTS - 2; k++)
      directed.push_back(mk_req(KIND_SEND, $urandom, 8'($urandom), $urandom,
                                (k == 3) ? 16'd7 : 16'($urandom_range(1, 400)),
                                4'($urandom)));
    directed.push_back(mk_req(KIND_SEND, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));
    directed.push_back(mk_req(KIND_RELEASE, 32'h0, 8'h00, 32'h0, 16'h0, 4'h0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[k]) offer_request(directed[k], pick_gap(k + 30));
    // hold the result side off while words keep coming, so the block backs up
    hold_off_due = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++)
      offer_request(random_request(k * 4 / RANDOM_ITEMS), pick_gap(k));
    in_chan.valid <= 1'b0;

    while (pool.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pool.mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    int pick, run, stall;
    bit held;
    held = 1'b0;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 45) stall = 0;
      else if (pick < 85) stall = $urandom_range(1, 3);
      else stall = $urandom_range(8, 40);
      run = ($urandom_range(0, 99) < 20) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      if (hold_off_due && !held) begin
        stall = HOLD_CYCLES;
        held = 1'b1;
      end
      if (stall != 0) begin
        out_chan.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_chan.ready <= 1'b1;
      repeat (run) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rsp_t got;
    if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      got.status = out_chan.status;
      got.slot_out = out_chan.slot_out;
      got.value_out = out_chan.value_out;
      got.expired_count = out_chan.expired_count;
      pool.check_result(got);
    end
  end

  // Count cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
